// ----- hdl/rgbfx_pkg.sv -----
`default_nettype none
package rgbfx_pkg;

  localparam int FULL_SCALE_BITS_DEF = 12;
  localparam int LEVEL_BITS          = 9;
  localparam int LEVEL_MAX           = 256;
  localparam int LOOP_STEP           = 4;
  localparam int AMBER_NUM           = 2720;
  localparam int FLICKER_BASE        = 128;
  localparam int DUTY_BITS           = 13;
  localparam int LEVEL_SHIFT         = 8;

  typedef enum logic [2:0] {
    FN_SET_COLOR = 3'd0,
    FN_INIT      = 3'd1,
    FN_ON        = 3'd2,
    FN_OFF       = 3'd3,
    FN_LOOP      = 3'd4,
    FN_FLICKER   = 3'd5,
    FN_BLINK     = 3'd6,
    FN_TICK      = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    FX_NONE    = 2'd0,
    FX_LOOP    = 2'd1,
    FX_FLICKER = 2'd2,
    FX_BLINK   = 2'd3
  } fx_t;

  typedef enum logic [1:0] {
    ST_DISABLED = 2'd0,
    ST_INIT     = 2'd1,
    ST_READY    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_LOOP_PERIOD  = 2'd0,
    REG_BLINK_PERIOD = 2'd1,
    REG_FLICKER_MIN  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_RED_UP   = 2'd0,
    PH_GREEN_UP = 2'd1,
    PH_BLUE_UP  = 2'd2
  } loop_phase_t;

  typedef enum logic [2:0] {
    G_IDLE,
    G_SQ,
    G_CU,
    G_RND,
    G_LV
  } g_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_LOAD,
    C_WAIT,
    C_EMIT
  } ctl_state_t;

endpackage
`default_nettype wire

// ----- hdl/rgbfx_gamma.sv -----
`default_nettype none
// Bit-serial shift-add unit: x*x, then *x, round, then *level >> 8.
module rgbfx_gamma #(
  parameter int FULL_SCALE_BITS = rgbfx_pkg::FULL_SCALE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [FULL_SCALE_BITS:0]   x,
  input  wire logic [rgbfx_pkg::LEVEL_BITS-1:0] lvl,
  output logic                            done,
  output logic [FULL_SCALE_BITS:0]        duty
);

  localparam int XW = FULL_SCALE_BITS + 1;
  localparam int AW = 3 * FULL_SCALE_BITS + 3;
  localparam int CW = $clog2(XW + 1);
  localparam int SH = 2 * FULL_SCALE_BITS - 1;

  rgbfx_pkg::g_state_t state_r, state_nxt;
  logic [AW-1:0] a_r, a_nxt, acc_r, acc_nxt, acc_sum, cube_shr;
  logic [XW-1:0] b_r, b_nxt, x_r, x_nxt, duty_r, duty_nxt, g_val;
  logic [rgbfx_pkg::LEVEL_BITS-1:0] lvl_r, lvl_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt, last;

  assign acc_sum  = acc_r + (b_r[0] ? a_r : '0);
  assign cube_shr = acc_r >> SH;
  assign g_val    = XW'((cube_shr + AW'(1)) >> 1);
  assign last     = (cnt_r == CW'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rgbfx_pkg::G_IDLE: if (start) state_nxt = rgbfx_pkg::G_SQ;
      rgbfx_pkg::G_SQ:   if (last) state_nxt = rgbfx_pkg::G_CU;
      rgbfx_pkg::G_CU:   if (last) state_nxt = rgbfx_pkg::G_RND;
      rgbfx_pkg::G_RND:  state_nxt = rgbfx_pkg::G_LV;
      rgbfx_pkg::G_LV:   if (last) state_nxt = rgbfx_pkg::G_IDLE;
      default:           state_nxt = rgbfx_pkg::G_IDLE;
    endcase
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    lvl_nxt  = lvl_r;
    duty_nxt = duty_r;
    done_nxt = 1'b0;
    unique case (state_r)
      rgbfx_pkg::G_IDLE: begin
        if (start) begin
          x_nxt   = x;
          lvl_nxt = lvl;
          a_nxt   = AW'(x);
          b_nxt   = x;
          acc_nxt = '0;
          cnt_nxt = CW'(XW);
        end
      end
      rgbfx_pkg::G_SQ, rgbfx_pkg::G_CU, rgbfx_pkg::G_LV: begin
        a_nxt   = a_r << 1;
        b_nxt   = b_r >> 1;
        acc_nxt = acc_sum;
        cnt_nxt = cnt_r - CW'(1);
        if (last && state_r == rgbfx_pkg::G_SQ) begin
          a_nxt   = acc_sum;
          b_nxt   = x_r;
          acc_nxt = '0;
          cnt_nxt = CW'(XW);
        end
        if (last && state_r == rgbfx_pkg::G_LV) begin
          done_nxt = 1'b1;
          duty_nxt = XW'(acc_sum >> rgbfx_pkg::LEVEL_SHIFT);
        end
      end
      rgbfx_pkg::G_RND: begin
        a_nxt   = AW'(g_val);
        b_nxt   = XW'(lvl_r);
        acc_nxt = '0;
        cnt_nxt = CW'(rgbfx_pkg::LEVEL_BITS);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rgbfx_pkg::G_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    lvl_r  <= lvl_nxt;
    duty_r <= duty_nxt;
  end

  assign done = done_r;
  assign duty = duty_r;

endmodule
`default_nettype wire

// ----- hdl/rgb_led_gamma_effect_controller_unit.sv -----
`default_nettype none
// Three-channel LED duty generator with gamma correction and color effects.
// One command or millisecond tick per input transfer, one status transfer out
// per command. Commands that rewrite the duties run the three channels one
// after another through a single bit-serial gamma unit: each channel runs the
// square and then the cube by shift-add over x, a rounding step and the
// shift-add brightness product by the level. A new command is taken while the
// previous result still waits on the output.
module rgb_led_gamma_effect_controller_unit #(
  parameter int FULL_SCALE_BITS = rgbfx_pkg::FULL_SCALE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // red[15:0] green[31:16] blue[47:32] level[63:48] rand_level[70:64] rand_delay[78:71]
  input  wire logic [79:0] in_tdata,
  // func[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // duty_red[12:0] duty_green[25:13] duty_blue[38:26] pwm_on[39] status[41:40]
  // effect_code[43:42]
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int XW        = FULL_SCALE_BITS + 1;
  localparam int LW        = rgbfx_pkg::LEVEL_BITS;
  localparam int FULL_INT  = 1 << FULL_SCALE_BITS;
  localparam int AMBER_INT = (rgbfx_pkg::AMBER_NUM * FULL_INT) >> 12;
  localparam int BRED_INT  = (256 * FULL_INT) >> 12;
  localparam logic [XW-1:0] FULL_C  = XW'(FULL_INT);
  localparam logic [XW-1:0] AMBER_C = XW'(AMBER_INT);
  localparam logic [XW-1:0] BRED_C  = XW'(BRED_INT);
  localparam logic [XW-1:0] STEP_C  = XW'(rgbfx_pkg::LOOP_STEP);
  localparam logic [LW-1:0] LMAX_C  = LW'(rgbfx_pkg::LEVEL_MAX);

  // config registers
  logic [7:0] loop_period_r, blink_period_r, flick_min_r;
  logic       cfg_wr;
  rgbfx_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = rgbfx_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      rgbfx_pkg::REG_LOOP_PERIOD:  cfg_prdata = 32'(loop_period_r);
      rgbfx_pkg::REG_BLINK_PERIOD: cfg_prdata = 32'(blink_period_r);
      rgbfx_pkg::REG_FLICKER_MIN:  cfg_prdata = 32'(flick_min_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_period_r  <= 8'd4;
      blink_period_r <= 8'd50;
      flick_min_r    <= 8'd5;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rgbfx_pkg::REG_LOOP_PERIOD:  loop_period_r  <= cfg_pwdata[7:0];
        rgbfx_pkg::REG_BLINK_PERIOD: blink_period_r <= cfg_pwdata[7:0];
        rgbfx_pkg::REG_FLICKER_MIN:  flick_min_r    <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // input fields
  rgbfx_pkg::func_t func;
  logic [15:0] in_red, in_green, in_blue, in_level;
  logic [6:0]  rand_level;
  logic [7:0]  rand_delay;

  assign func       = rgbfx_pkg::func_t'(in_tuser);
  assign in_red     = in_tdata[15:0];
  assign in_green   = in_tdata[31:16];
  assign in_blue    = in_tdata[47:32];
  assign in_level   = in_tdata[63:48];
  assign rand_level = in_tdata[70:64];
  assign rand_delay = in_tdata[78:71];

  function automatic logic [XW-1:0] sat_color(input logic [15:0] v);
    return (32'(v) > 32'(FULL_INT)) ? FULL_C : XW'(v);
  endfunction

  // state
  rgbfx_pkg::ctl_state_t  state_r, state_nxt;
  rgbfx_pkg::status_t     status_r, status_nxt;
  rgbfx_pkg::fx_t         fx_code_r, fx_code_nxt, fx_kind_r, fx_kind_nxt;
  rgbfx_pkg::loop_phase_t fx_phase_r, fx_phase_nxt;
  logic [XW-1:0] user_color_r [3], user_color_nxt [3];
  logic [XW-1:0] fx_color_r [3], fx_color_nxt [3];
  logic [XW-1:0] duty_r [3], duty_nxt [3];
  logic [XW-1:0] job_color_r [3], job_color_nxt [3];
  logic [LW-1:0] user_level_r, user_level_nxt, fx_level_r, fx_level_nxt;
  logic [LW-1:0] job_lvl_r, job_lvl_nxt;
  logic [7:0]    countdown_r, countdown_nxt;
  logic          fx_running_r, fx_running_nxt, out_en_r, out_en_nxt;
  logic [1:0]    ch_r, ch_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [47:0]   out_data_r, out_data_nxt;

  logic accept, run_job, do_start, do_step, emit_load, g_start, g_done;
  rgbfx_pkg::fx_t start_kind, step_kind;
  logic [XW-1:0] g_duty;

  // control outputs
  always_comb begin
    in_tready = (state_r == rgbfx_pkg::C_IDLE);
    g_start   = (state_r == rgbfx_pkg::C_LOAD);
    emit_load = (state_r == rgbfx_pkg::C_EMIT) && (!out_valid_r || out_tready);
  end

  assign accept = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rgbfx_pkg::C_IDLE: if (in_tvalid) state_nxt = run_job ? rgbfx_pkg::C_LOAD
                                                            : rgbfx_pkg::C_EMIT;
      rgbfx_pkg::C_LOAD: state_nxt = rgbfx_pkg::C_WAIT;
      rgbfx_pkg::C_WAIT: if (g_done) state_nxt = (ch_r == 2'd2) ? rgbfx_pkg::C_EMIT
                                                                : rgbfx_pkg::C_LOAD;
      rgbfx_pkg::C_EMIT: if (emit_load) state_nxt = rgbfx_pkg::C_IDLE;
      default:           state_nxt = rgbfx_pkg::C_IDLE;
    endcase
  end

  // command decode and effect stepping
  always_comb begin
    status_nxt     = status_r;
    fx_code_nxt    = fx_code_r;
    fx_kind_nxt    = fx_kind_r;
    fx_phase_nxt   = fx_phase_r;
    user_color_nxt = user_color_r;
    fx_color_nxt   = fx_color_r;
    duty_nxt       = duty_r;
    job_color_nxt  = job_color_r;
    user_level_nxt = user_level_r;
    fx_level_nxt   = fx_level_r;
    job_lvl_nxt    = job_lvl_r;
    countdown_nxt  = countdown_r;
    fx_running_nxt = fx_running_r;
    out_en_nxt     = out_en_r;
    ch_nxt         = ch_r;
    run_job        = 1'b0;
    do_start       = 1'b0;
    do_step        = 1'b0;
    start_kind     = rgbfx_pkg::FX_NONE;
    step_kind      = fx_kind_r;

    if (accept) begin
      ch_nxt = 2'd0;
      unique case (func)
        rgbfx_pkg::FN_SET_COLOR: begin
          fx_running_nxt    = 1'b0;
          user_color_nxt[0] = sat_color(in_red);
          user_color_nxt[1] = sat_color(in_green);
          user_color_nxt[2] = sat_color(in_blue);
          user_level_nxt    = (in_level > 16'(rgbfx_pkg::LEVEL_MAX)) ? LMAX_C
                                                                     : LW'(in_level);
          job_color_nxt     = user_color_nxt;
          job_lvl_nxt       = user_level_nxt;
          run_job           = 1'b1;
        end
        rgbfx_pkg::FN_INIT: begin
          status_nxt     = rgbfx_pkg::ST_INIT;
          fx_code_nxt    = rgbfx_pkg::FX_NONE;
          out_en_nxt     = 1'b0;
          for (int i = 0; i < 3; i++) begin
            duty_nxt[i]       = '0;
            user_color_nxt[i] = FULL_C;
          end
          user_level_nxt = LMAX_C;
        end
        rgbfx_pkg::FN_ON: begin
          if (status_r != rgbfx_pkg::ST_DISABLED) begin
            out_en_nxt    = 1'b1;
            job_color_nxt = user_color_r;
            job_lvl_nxt   = user_level_r;
            run_job       = 1'b1;
            status_nxt    = rgbfx_pkg::ST_READY;
            fx_code_nxt   = rgbfx_pkg::FX_NONE;
          end
        end
        rgbfx_pkg::FN_OFF: begin
          if (status_r != rgbfx_pkg::ST_DISABLED) begin
            fx_running_nxt = 1'b0;
            out_en_nxt     = 1'b0;
            status_nxt     = rgbfx_pkg::ST_INIT;
            fx_code_nxt    = rgbfx_pkg::FX_NONE;
          end
        end
        rgbfx_pkg::FN_LOOP: begin
          if (status_r == rgbfx_pkg::ST_READY && fx_code_r == rgbfx_pkg::FX_NONE) begin
            do_start   = 1'b1;
            start_kind = rgbfx_pkg::FX_LOOP;
          end
        end
        rgbfx_pkg::FN_FLICKER: begin
          if (status_r == rgbfx_pkg::ST_READY && fx_code_r == rgbfx_pkg::FX_NONE) begin
            do_start   = 1'b1;
            start_kind = rgbfx_pkg::FX_FLICKER;
          end
        end
        rgbfx_pkg::FN_BLINK: begin
          if (status_r == rgbfx_pkg::ST_READY) begin
            do_start   = 1'b1;
            start_kind = rgbfx_pkg::FX_BLINK;
          end
        end
        rgbfx_pkg::FN_TICK: begin
          if (fx_running_r) begin
            if (countdown_r <= 8'd1) do_step = 1'b1;
            else countdown_nxt = countdown_r - 8'd1;
          end
        end
      endcase
    end

    if (do_start) begin
      fx_phase_nxt   = rgbfx_pkg::PH_RED_UP;
      fx_running_nxt = 1'b1;
      fx_kind_nxt    = start_kind;
      fx_level_nxt   = LMAX_C;
      if (start_kind == rgbfx_pkg::FX_LOOP) begin
        fx_color_nxt[0] = '0;
        fx_color_nxt[1] = '0;
        fx_color_nxt[2] = FULL_C;
      end else begin
        for (int i = 0; i < 3; i++) fx_color_nxt[i] = FULL_C;
      end
      do_step     = 1'b1;
      step_kind   = start_kind;
      fx_code_nxt = start_kind;
    end

    if (do_step) begin
      unique case (step_kind)
        rgbfx_pkg::FX_LOOP: begin
          unique case (fx_phase_nxt)
            rgbfx_pkg::PH_RED_UP: begin
              fx_color_nxt[2] = fx_color_nxt[2] - STEP_C;
              fx_color_nxt[0] = fx_color_nxt[0] + STEP_C;
              if (fx_color_nxt[0] == FULL_C) fx_phase_nxt = rgbfx_pkg::PH_GREEN_UP;
            end
            rgbfx_pkg::PH_GREEN_UP: begin
              fx_color_nxt[0] = fx_color_nxt[0] - STEP_C;
              fx_color_nxt[1] = fx_color_nxt[1] + STEP_C;
              if (fx_color_nxt[1] == FULL_C) fx_phase_nxt = rgbfx_pkg::PH_BLUE_UP;
            end
            rgbfx_pkg::PH_BLUE_UP: begin
              fx_color_nxt[1] = fx_color_nxt[1] - STEP_C;
              fx_color_nxt[2] = fx_color_nxt[2] + STEP_C;
              if (fx_color_nxt[2] == FULL_C) fx_phase_nxt = rgbfx_pkg::PH_RED_UP;
            end
            default: ;
          endcase
          job_color_nxt = fx_color_nxt;
          job_lvl_nxt   = fx_level_nxt;
          countdown_nxt = loop_period_r;
          run_job       = 1'b1;
        end
        rgbfx_pkg::FX_FLICKER: begin
          fx_level_nxt     = LW'(rand_level) + LW'(rgbfx_pkg::FLICKER_BASE);
          countdown_nxt    = (rand_delay < flick_min_r) ? flick_min_r : rand_delay;
          job_color_nxt[0] = FULL_C;
          job_color_nxt[1] = AMBER_C;
          job_color_nxt[2] = '0;
          job_lvl_nxt      = fx_level_nxt;
          run_job          = 1'b1;
        end
        rgbfx_pkg::FX_BLINK: begin
          fx_level_nxt     = fx_level_nxt ^ LMAX_C;
          countdown_nxt    = blink_period_r;
          job_color_nxt[0] = BRED_C;
          job_color_nxt[1] = '0;
          job_color_nxt[2] = '0;
          job_lvl_nxt      = fx_level_nxt;
          run_job          = 1'b1;
        end
        rgbfx_pkg::FX_NONE: ;
      endcase
    end

    if (state_r == rgbfx_pkg::C_WAIT && g_done) begin
      duty_nxt[ch_r] = g_duty;
      ch_nxt         = ch_r + 2'd1;
    end
  end

  rgbfx_gamma #(
    .FULL_SCALE_BITS(FULL_SCALE_BITS)
  ) u_gamma (
    .clk   (clk),
    .rst_n (rst_n),
    .start (g_start),
    .x     (job_color_r[ch_r]),
    .lvl   (job_lvl_r),
    .done  (g_done),
    .duty  (g_duty)
  );

  // output register
  always_comb begin
    out_data_nxt = {4'b0000, fx_code_r, status_r, out_en_r,
                    rgbfx_pkg::DUTY_BITS'(duty_r[2]),
                    rgbfx_pkg::DUTY_BITS'(duty_r[1]),
                    rgbfx_pkg::DUTY_BITS'(duty_r[0])};
    if (emit_load)       out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rgbfx_pkg::C_IDLE;
      status_r     <= rgbfx_pkg::ST_DISABLED;
      fx_code_r    <= rgbfx_pkg::FX_NONE;
      fx_kind_r    <= rgbfx_pkg::FX_NONE;
      fx_phase_r   <= rgbfx_pkg::PH_RED_UP;
      user_level_r <= '0;
      fx_level_r   <= '0;
      countdown_r  <= '0;
      fx_running_r <= 1'b0;
      out_en_r     <= 1'b0;
      ch_r         <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        user_color_r[i] <= '0;
        fx_color_r[i]   <= '0;
        duty_r[i]       <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      status_r     <= status_nxt;
      fx_code_r    <= fx_code_nxt;
      fx_kind_r    <= fx_kind_nxt;
      fx_phase_r   <= fx_phase_nxt;
      user_level_r <= user_level_nxt;
      fx_level_r   <= fx_level_nxt;
      countdown_r  <= countdown_nxt;
      fx_running_r <= fx_running_nxt;
      out_en_r     <= out_en_nxt;
      ch_r         <= ch_nxt;
      out_valid_r  <= out_valid_nxt;
      user_color_r <= user_color_nxt;
      fx_color_r   <= fx_color_nxt;
      duty_r       <= duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_color_r <= job_color_nxt;
    job_lvl_r   <= job_lvl_nxt;
    if (emit_load) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- tb/sv/tb_rgb_led_gamma_effect_controller_unit.sv -----
`timescale 1ns / 1ps
module tb_rgb_led_gamma_effect_controller_unit;

  localparam int FULL = 4096;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // packed from the top bit down: effect_code ends up in the highest bits
  typedef struct packed {
    logic [1:0]  fx;
    logic [1:0]  status;
    logic        pwm_on;
    logic [12:0] duty_b;
    logic [12:0] duty_g;
    logic [12:0] duty_r;
  } led_state_t;

  led_state_t expected_q[$];
  int         n_fail;
  int         hold_cycles;
  bit         rx_random;

  // predictor state
  int unsigned p_loop, p_blink, p_fmin;
  int unsigned u_col[3], u_lvl, f_col[3], f_lvl, f_phase, f_run, cnt;
  int unsigned st, fcode, oen, duty[3], kind;

  rgb_led_gamma_effect_controller_unit uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned sat_to(int unsigned v, int unsigned top);
    return v > top ? top : v;
  endfunction

  function automatic int unsigned gamma(int unsigned x, int unsigned lvl);
    longint unsigned c, g;
    c = longint'(x) * x * x;
    g = ((c >> 23) + 1) >> 1;
    return int'((g * lvl) >> 8) & 32'h1fff;
  endfunction

  function automatic void load_duty(int unsigned r, int unsigned g, int unsigned b,
                                    int unsigned lvl);
    lvl = sat_to(lvl, rgbfx_pkg::LEVEL_MAX);
    duty[0] = gamma(sat_to(r, FULL), lvl);
    duty[1] = gamma(sat_to(g, FULL), lvl);
    duty[2] = gamma(sat_to(b, FULL), lvl);
  endfunction

  function automatic void fx_advance(int unsigned rl, int unsigned rd);
    if (kind == rgbfx_pkg::FX_LOOP) begin
      unique case (f_phase)
        0: begin
          f_col[2] = (f_col[2] - 4) & 16'hffff; f_col[0] = (f_col[0] + 4) & 16'hffff;
          if (f_col[0] == FULL) f_phase = 1;
        end
        1: begin
          f_col[0] = (f_col[0] - 4) & 16'hffff; f_col[1] = (f_col[1] + 4) & 16'hffff;
          if (f_col[1] == FULL) f_phase = 2;
        end
        2: begin
          f_col[1] = (f_col[1] - 4) & 16'hffff; f_col[2] = (f_col[2] + 4) & 16'hffff;
          if (f_col[2] == FULL) f_phase = 0;
        end
        default: ;
      endcase
      load_duty(f_col[0], f_col[1], f_col[2], f_lvl);
      cnt = p_loop;
    end else if (kind == rgbfx_pkg::FX_FLICKER) begin
      f_lvl = rl + 128;
      if (rd < p_fmin) rd = p_fmin;
      load_duty(FULL, rgbfx_pkg::AMBER_NUM, 0, f_lvl);
      cnt = rd & 8'hff;
    end else if (kind == rgbfx_pkg::FX_BLINK) begin
      f_lvl ^= 256;
      load_duty(256, 0, 0, f_lvl);
      cnt = p_blink;
    end
  endfunction

  function automatic void fx_start(int unsigned k, int unsigned rl, int unsigned rd);
    f_phase = 0; f_run = 1; kind = k; f_lvl = rgbfx_pkg::LEVEL_MAX;
    if (k == rgbfx_pkg::FX_LOOP) begin
      f_col[0] = 0; f_col[1] = 0; f_col[2] = FULL;
    end else begin
      f_col[0] = FULL; f_col[1] = FULL; f_col[2] = FULL;
    end
    fx_advance(rl, rd);
    fcode = k;
  endfunction

  function automatic led_state_t predict_led(rgbfx_pkg::func_t fn, logic [79:0] d);
    led_state_t e;
    int unsigned rl, rd;
    rl = d[70:64];
    rd = d[78:71];
    unique case (fn)
      rgbfx_pkg::FN_SET_COLOR: begin
        f_run = 0;
        u_col[0] = sat_to(d[15:0], FULL); u_col[1] = sat_to(d[31:16], FULL);
        u_col[2] = sat_to(d[47:32], FULL); u_lvl = sat_to(d[63:48], rgbfx_pkg::LEVEL_MAX);
        load_duty(u_col[0], u_col[1], u_col[2], u_lvl);
      end
      rgbfx_pkg::FN_INIT: begin
        st = rgbfx_pkg::ST_INIT; fcode = rgbfx_pkg::FX_NONE; oen = 0;
        duty[0] = 0; duty[1] = 0; duty[2] = 0;
        u_col[0] = FULL; u_col[1] = FULL; u_col[2] = FULL; u_lvl = rgbfx_pkg::LEVEL_MAX;
      end
      rgbfx_pkg::FN_ON: if (st != rgbfx_pkg::ST_DISABLED) begin
        oen = 1; load_duty(u_col[0], u_col[1], u_col[2], u_lvl);
        st = rgbfx_pkg::ST_READY; fcode = rgbfx_pkg::FX_NONE;
      end
      rgbfx_pkg::FN_OFF: if (st != rgbfx_pkg::ST_DISABLED) begin
        f_run = 0; oen = 0; st = rgbfx_pkg::ST_INIT; fcode = rgbfx_pkg::FX_NONE;
      end
      rgbfx_pkg::FN_LOOP, rgbfx_pkg::FN_FLICKER:
        if (st == rgbfx_pkg::ST_READY && fcode == rgbfx_pkg::FX_NONE)
          fx_start(fn == rgbfx_pkg::FN_LOOP ? rgbfx_pkg::FX_LOOP : rgbfx_pkg::FX_FLICKER,
                   rl, rd);
      rgbfx_pkg::FN_BLINK: if (st == rgbfx_pkg::ST_READY) fx_start(rgbfx_pkg::FX_BLINK, rl, rd);
      default: if (f_run != 0) begin
        if (cnt <= 1) fx_advance(rl, rd);
        else cnt--;
      end
    endcase
    e.duty_r = 13'(duty[0]); e.duty_g = 13'(duty[1]); e.duty_b = 13'(duty[2]);
    e.pwm_on = 1'(oen); e.status = 2'(st); e.fx = 2'(fcode);
    return e;
  endfunction

  // starts and ends at a falling edge; valid stays up when the next item follows at once
  task automatic send_cmd(rgbfx_pkg::func_t fn, logic [79:0] d);
    int gap;
    gap = $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= fn;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_led(fn, d));
    @(negedge clk);
  endtask

  function automatic logic [79:0] pack_cmd(int unsigned r, int unsigned g, int unsigned b,
                                           int unsigned l, int unsigned rl,
                                           int unsigned rd);
    return {1'b0, rd[7:0], rl[6:0], l[15:0], b[15:0], g[15:0], r[15:0]};
  endfunction

  function automatic logic [79:0] rand_data();
    return {1'b0, 8'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom)};
  endfunction

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (150) @(posedge clk);
  endtask

  task automatic cfg_write(rgbfx_pkg::reg_idx_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= 32'(val);
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    unique case (idx)
      rgbfx_pkg::REG_LOOP_PERIOD:  p_loop = val;
      rgbfx_pkg::REG_BLINK_PERIOD: p_blink = val;
      default:                     p_fmin = val;
    endcase
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // result checker and receiver back-pressure
  initial begin
    led_state_t got, want;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = out_tdata[43:0];
        if (expected_q.size() == 0) begin
          $error("unexpected transfer %h", got);
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          if (got.duty_r !== want.duty_r) begin
            $error("duty_red exp %0d got %0d", want.duty_r, got.duty_r); n_fail++;
          end
          if (got.duty_g !== want.duty_g) begin
            $error("duty_green exp %0d got %0d", want.duty_g, got.duty_g); n_fail++;
          end
          if (got.duty_b !== want.duty_b) begin
            $error("duty_blue exp %0d got %0d", want.duty_b, got.duty_b); n_fail++;
          end
          if (got.pwm_on !== want.pwm_on) begin
            $error("pwm_on exp %0d got %0d", want.pwm_on, got.pwm_on); n_fail++;
          end
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); n_fail++;
          end
          if (got.fx !== want.fx) begin
            $error("effect_code exp %0d got %0d", want.fx, got.fx); n_fail++;
          end
        end
      end
    end
  end

  initial begin
    int w;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 0;
        hold_cycles--;
      end else if (rx_random) begin
        w = $urandom_range(0, 11);
        if (w == 0 || $urandom_range(0, 3) == 0) out_tready <= 1;
        else begin
          out_tready <= 0;
          repeat (w) @(negedge clk);
          out_tready <= 1;
        end
      end else out_tready <= 1;
    end
  end

  task automatic test_directed();
    send_cmd(rgbfx_pkg::FN_ON, pack_cmd(0, 0, 0, 0, 0, 0));       // ignored while disabled
    send_cmd(rgbfx_pkg::FN_LOOP, 80'h0);
    send_cmd(rgbfx_pkg::FN_SET_COLOR, pack_cmd(65535, 4096, 4095, 65535, 0, 0));
    send_cmd(rgbfx_pkg::FN_SET_COLOR, pack_cmd(0, 1, 2000, 0, 0, 0));
    send_cmd(rgbfx_pkg::FN_INIT, 80'h0);
    send_cmd(rgbfx_pkg::FN_LOOP, 80'h0);                          // not ready yet
    send_cmd(rgbfx_pkg::FN_ON, 80'h0);
    send_cmd(rgbfx_pkg::FN_LOOP, 80'h0);
    repeat (6) send_cmd(rgbfx_pkg::FN_TICK, rand_data());
    send_cmd(rgbfx_pkg::FN_FLICKER, 80'h0);                       // code busy: ignored
    send_cmd(rgbfx_pkg::FN_BLINK, 80'h0);                         // blink overrides code
    send_cmd(rgbfx_pkg::FN_ON, 80'h0);
    send_cmd(rgbfx_pkg::FN_FLICKER, pack_cmd(0, 0, 0, 0, 127, 0));
    send_cmd(rgbfx_pkg::FN_TICK, pack_cmd(0, 0, 0, 0, 0, 255));
    send_cmd(rgbfx_pkg::FN_SET_COLOR, pack_cmd(4097, 300, 65535, 256, 0, 0));
    send_cmd(rgbfx_pkg::FN_TICK, 80'h0);                          // no effect running
    send_cmd(rgbfx_pkg::FN_OFF, 80'h0);
    send_cmd(rgbfx_pkg::FN_BLINK, 80'h0);
    send_cmd(rgbfx_pkg::FN_ON, 80'h0);
    drain();
  endtask

  task automatic test_config_extremes();
    cfg_write(rgbfx_pkg::REG_LOOP_PERIOD, 1);
    cfg_write(rgbfx_pkg::REG_BLINK_PERIOD, 1);
    cfg_write(rgbfx_pkg::REG_FLICKER_MIN, 255);
    send_cmd(rgbfx_pkg::FN_LOOP, 80'h0);
    repeat (10) send_cmd(rgbfx_pkg::FN_TICK, 80'h0);
    send_cmd(rgbfx_pkg::FN_BLINK, 80'h0);
    repeat (4) send_cmd(rgbfx_pkg::FN_TICK, 80'h0);
    send_cmd(rgbfx_pkg::FN_ON, 80'h0);
    send_cmd(rgbfx_pkg::FN_FLICKER, rand_data());
    repeat (4) send_cmd(rgbfx_pkg::FN_TICK, rand_data());
    send_cmd(rgbfx_pkg::FN_ON, 80'h0);
    drain();
    cfg_write(rgbfx_pkg::REG_LOOP_PERIOD, 255);
    cfg_write(rgbfx_pkg::REG_BLINK_PERIOD, 255);
    cfg_write(rgbfx_pkg::REG_FLICKER_MIN, 1);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (12) send_cmd(rgbfx_pkg::FN_TICK, rand_data());
    drain();
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_cmd(rgbfx_pkg::FN_TICK, rand_data());
      else if (r < 62) send_cmd(rgbfx_pkg::FN_ON, rand_data());
      else if (r < 67) send_cmd(rgbfx_pkg::FN_OFF, rand_data());
      else if (r < 70) send_cmd(rgbfx_pkg::FN_INIT, rand_data());
      else if (r < 77) send_cmd(rgbfx_pkg::FN_SET_COLOR, rand_data());
      else if (r < 84) send_cmd(rgbfx_pkg::FN_LOOP, rand_data());
      else if (r < 91) send_cmd(rgbfx_pkg::FN_FLICKER, rand_data());
      else send_cmd(rgbfx_pkg::FN_BLINK, rand_data());
      if (i % 150 == 149) begin
        drain();
        cfg_write(rgbfx_pkg::REG_LOOP_PERIOD, 8'($urandom_range(1, 8)));
        cfg_write(rgbfx_pkg::REG_BLINK_PERIOD, 8'($urandom_range(1, 8)));
        cfg_write(rgbfx_pkg::REG_FLICKER_MIN, 8'($urandom_range(1, 255)));
      end
    end
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tuser = 0; out_tready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    n_fail = 0; hold_cycles = 0; rx_random = 0;
    p_loop = 4; p_blink = 50; p_fmin = 5;
    for (int i = 0; i < 3; i++) begin
      u_col[i] = 0; f_col[i] = 0; duty[i] = 0;
    end
    u_lvl = 0; f_lvl = 0; f_phase = 0; f_run = 0; cnt = 0;
    st = 0; fcode = 0; oen = 0; kind = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;
    test_directed();
    rx_random = 1;
    test_config_extremes();
    test_backpressure();
    test_random(450);
    rx_random = 0;
    test_random(100);
    rx_random = 1;
    test_random(300);
    drain();
    if (n_fail == 0 && expected_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
